// ===== sv/kst_pkg.sv =====
// Package with the shared types, codes and constants of the key slot table.
package kst_pkg;

   localparam int TABLE_DEPTH_DEF   = 16;
   localparam int KEY_BYTES_MAX_DEF = 8;

   localparam int KEY_VALUE_W  = 64;
   localparam int KEY_BYTES_W  = 4;
   localparam int STATUS_W     = 2;
   localparam int SLOT_INDEX_W = 4;

   localparam logic [KEY_BYTES_W-1:0] KEY_BYTES_RESET = 4'd8;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RESERVED  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_COMMIT
   } kst_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic compare;
      logic commit;
   } kst_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_free;
   } kst_stat_type;

endpackage

// ===== sv/kst_req_if.sv =====
// Interface of the request channel: valid, ready and one request beat.
interface kst_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 opcode;
   logic [kst_pkg::KEY_VALUE_W-1:0]      key_value;

   modport source (output valid, output opcode, output key_value, input ready);
   modport sink   (input valid, input opcode, input key_value, output ready);
endinterface

// ===== sv/kst_rsp_if.sv =====
// Interface of the response channel: valid, ready and one response beat.
interface kst_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [kst_pkg::STATUS_W-1:0]         status;
   logic [kst_pkg::SLOT_INDEX_W-1:0]     slot_index;

   modport source (output valid, output status, output slot_index, input ready);
   modport sink   (input valid, input status, input slot_index, output ready);
endinterface

// ===== sv/key_slot_table_core.sv =====
// Top level of the key slot table: controller, datapath and the channel ports.
//
// The key slot table holds TABLE_DEPTH slots, each with a valid mark that reset
// clears. An insert beat stores the low key_bytes bytes of its key in the
// lowest-numbered free slot and answers that slot with status done, or answers
// table full. A remove beat clears the lowest-numbered valid slot whose stored
// key equals the given key in its low key_bytes bytes, or answers not found;
// duplicate keys are allowed and empty slots never match. The slot index is
// zero whenever the status is not done. The key_bytes register (reset value
// 8) is written through csr_wr_en and csr_wr_data; the user must write it
// only while the table is idle, as the block does not enforce this. Values
// above KEY_BYTES_MAX act as KEY_BYTES_MAX. A request passes an accept step,
// a compare step that compares every slot in parallel and registers the hit
// vector, and a commit step that picks the lowest hit, updates the slot and
// loads the response register; the next request is taken only after that
// commit. The response register lets the next request be accepted while the
// previous response still waits; only the commit step waits for it to be free.
module key_slot_table_core #(
   parameter int TABLE_DEPTH   = kst_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BYTES_MAX = kst_pkg::KEY_BYTES_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   kst_req_if.sink                         req_chan,
   kst_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [kst_pkg::KEY_BYTES_W-1:0] csr_wr_data
);

   kst_pkg::kst_cmd_type  cmd;
   kst_pkg::kst_stat_type stat;

   // The controller only decides when each step happens.
   kst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath owns all table state, the key length register and the
   // response register.
   kst_datapath #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .KEY_BYTES_MAX (KEY_BYTES_MAX)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_opcode     (req_chan.opcode),
      .req_key_value  (req_chan.key_value),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_status     (rsp_chan.status),
      .rsp_slot_index (rsp_chan.slot_index)
   );

endmodule

// ===== sv/kst_ctrl.sv =====
// Controller state machine that sequences accept, compare and commit.
module kst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kst_pkg::kst_stat_type stat,
   output kst_pkg::kst_cmd_type  cmd
);

   kst_pkg::kst_state_type state_ff;
   kst_pkg::kst_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kst_pkg::ST_IDLE: begin
            if (req_valid) state_in = kst_pkg::ST_COMPARE;
         end
         kst_pkg::ST_COMPARE: begin
            state_in = kst_pkg::ST_COMMIT;
         end
         kst_pkg::ST_COMMIT: begin
            // Wait here while the previous response still occupies the output register.
            if (stat.rsp_free) state_in = kst_pkg::ST_IDLE;
         end
         default: begin
            state_in = kst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.load_req = 1'b0;
      cmd.compare  = 1'b0;
      cmd.commit   = 1'b0;
      case (state_ff)
         kst_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         kst_pkg::ST_COMPARE: begin
            cmd.compare = 1'b1;
         end
         kst_pkg::ST_COMMIT: begin
            cmd.commit = stat.rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/kst_datapath.sv =====
// Datapath with the slot registers, parallel compare, slot pick and response register.
module kst_datapath #(
   parameter int TABLE_DEPTH   = kst_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BYTES_MAX = kst_pkg::KEY_BYTES_MAX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  kst_pkg::kst_cmd_type               cmd,
   output kst_pkg::kst_stat_type              stat,
   input  logic                               csr_wr_en,
   input  logic [kst_pkg::KEY_BYTES_W-1:0]    csr_wr_data,
   input  logic                               req_opcode,
   input  logic [kst_pkg::KEY_VALUE_W-1:0]    req_key_value,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [kst_pkg::STATUS_W-1:0]       rsp_status,
   output logic [kst_pkg::SLOT_INDEX_W-1:0]   rsp_slot_index
);

   localparam int KEY_W = 8 * KEY_BYTES_MAX;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [kst_pkg::KEY_BYTES_W-1:0]     key_bytes_ff;
   logic [kst_pkg::KEY_BYTES_W-1:0]     key_bytes_in;
   logic                                op_ff;
   logic [KEY_W-1:0]                    key_ff;
   logic [TABLE_DEPTH-1:0]              hit_ff;
   logic [TABLE_DEPTH-1:0]              hit_in;
   logic [TABLE_DEPTH-1:0]              valid_ff;
   logic [TABLE_DEPTH-1:0]              valid_in;
   logic [KEY_W-1:0]                    slot_key_ff [TABLE_DEPTH];
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [kst_pkg::STATUS_W-1:0]        rsp_status_ff;
   logic [kst_pkg::STATUS_W-1:0]        rsp_status_in;
   logic [kst_pkg::SLOT_INDEX_W-1:0]    rsp_slot_ff;
   logic [kst_pkg::SLOT_INDEX_W-1:0]    rsp_slot_in;

   logic [kst_pkg::KEY_BYTES_W-1:0]     used_bytes;
   logic [KEY_W-1:0]                    key_mask;
   logic                                pick_found;
   logic [IDX_W-1:0]                    pick_idx;
   logic [31:0]                         pick_idx_wide;

   // Byte count in force, saturated at the stored key width.
   always_comb begin
      if (key_bytes_ff > kst_pkg::KEY_BYTES_W'(KEY_BYTES_MAX)) begin
         used_bytes = kst_pkg::KEY_BYTES_W'(KEY_BYTES_MAX);
      end else begin
         used_bytes = key_bytes_ff;
      end
   end

   always_comb begin
      for (int b = 0; b < KEY_W; b++) begin
         key_mask[b] = (kst_pkg::KEY_BYTES_W'(b / 8) < used_bytes);
      end
   end

   assign key_bytes_in = csr_wr_en ? csr_wr_data : key_bytes_ff;

   // One comparator per slot; empty slots never match a remove.
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (op_ff == kst_pkg::OP_INSERT) begin
            hit_in[i] = ~valid_ff[i];
         end else begin
            hit_in[i] = valid_ff[i] & (((slot_key_ff[i] ^ key_ff) & key_mask) == '0);
         end
      end
   end

   // Lowest-numbered hit wins.
   always_comb begin
      pick_found = |hit_ff;
      pick_idx   = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (hit_ff[i]) pick_idx = IDX_W'(i);
      end
   end

   assign pick_idx_wide = 32'(pick_idx);

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit && pick_found) begin
         valid_in[pick_idx] = (op_ff == kst_pkg::OP_INSERT);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (pick_found) begin
            rsp_status_in = kst_pkg::STATUS_DONE;
            rsp_slot_in   = pick_idx_wide[kst_pkg::SLOT_INDEX_W-1:0];
         end else begin
            rsp_status_in = (op_ff == kst_pkg::OP_INSERT) ? kst_pkg::STATUS_FULL
                                                          : kst_pkg::STATUS_NOT_FOUND;
            rsp_slot_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff <= kst_pkg::KEY_BYTES_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_bytes_ff <= key_bytes_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_opcode;
         key_ff <= req_key_value[KEY_W-1:0] & key_mask;
      end
      if (cmd.compare) begin
         hit_ff <= hit_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (cmd.commit && pick_found && (op_ff == kst_pkg::OP_INSERT) &&
             (pick_idx == IDX_W'(i))) begin
            slot_key_ff[i] <= key_ff;
         end
      end
   end

   assign stat.rsp_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

// ===== sv/kst_checker.sv =====
// Port-level checker for the key slot table and its bind to the top level.
module kst_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [kst_pkg::STATUS_W-1:0]      rsp_status,
   input logic [kst_pkg::SLOT_INDEX_W-1:0]  rsp_slot_index
);

   // A stalled response beat holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot_index))
      else $error("stalled response beat changed");

   // Only one request is in work at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != kst_pkg::STATUS_RESERVED)
      else $error("reserved status code on response");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != kst_pkg::STATUS_DONE |-> rsp_slot_index == '0)
      else $error("slot index not zero on a failed request");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind key_slot_table_core kst_checker u_kst_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_slot_index (rsp_chan.slot_index)
);
